FILE: rtl/assert_macros.svh
// Assertion helpers for the sorted set engine checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted set engine: assertion failed");

// Next-cycle implication, disabled during reset
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted set engine: assertion failed");

`endif

FILE: rtl/sse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

  localparam int DATA_W       = 32;
  localparam int DEF_CAPACITY = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_DELETED   = 3'd6;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] value;
  } sse_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] entry_count;
  } sse_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/sse_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_set_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted set engine: a bounded set of distinct signed 32-bit values held in
// order in a single-port-read, single-port-write RAM.
// Request: drive in_req (opcode, value) with start high; it is taken at a
// clock edge where busy is low. busy then stays high until the result.
// Result: out_rsp (status, entry_count) is shown for exactly one cycle with
// out_valid high; the receiver cannot stall, so it must take it then.
// busy is already low in that cycle, so the next request may go in with it.
// Steps: the scan reads then compares one entry at a time from index 0
//   up to the match or the last entry; an empty set skips the scan.
//   insert   scan, decide, then move each entry from the insert
//            position up (read then write) and write the new value,
//   delete   scan, decide, then move each later entry down (read, write),
//   search   scan, then decide.
// The speed is set by the one RAM read port, used once per entry visited
// or moved. One request at a time.
// Configuration: cfg_data (descending order) is written when cfg_valid is
// high; cfg_ready is always high. Write it only while idle.
// Reset (synchronous, rst_n low) empties the set and selects ascending order;
// the RAM itself is not cleared.

module sorted_set_engine_top #(
  parameter int CAPACITY = sse_pkg::DEF_CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire sse_pkg::sse_req_t in_req,
  output logic                   out_valid,
  output sse_pkg::sse_rsp_t      out_rsp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);

  import sse_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN_RD  = 7'b0000010,
    S_SCAN_CMP = 7'b0000100,
    S_DECIDE   = 7'b0001000,
    S_MV_RD    = 7'b0010000,
    S_MV_WR    = 7'b0100000,
    S_WR_NEW   = 7'b1000000
  } state_t;

  state_t   state_r, state_nxt;
  sse_req_t req_r, req_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] fidx_r, fidx_nxt;
  logic          pos_hit_r, pos_hit_nxt;
  logic          found_r, found_nxt;
  logic          desc_r;
  logic          out_valid_r, out_valid_nxt;
  sse_rsp_t      out_rsp_r, out_rsp_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic          ent_eq, ent_after, last_scan, is_ins;
  logic [AW-1:0] ins_pos;

  sse_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign cfg_ready = 1'b1;

  assign is_ins    = (req_r.opcode == OP_INSERT);
  assign ent_eq    = (ram_rdata == req_r.value);
  assign ent_after = desc_r ? ($signed(ram_rdata) < req_r.value)
                            : (req_r.value < $signed(ram_rdata));
  assign last_scan = ((CW'(idx_r) + CW'(1)) == count_r);
  assign ins_pos   = pos_hit_r ? pos_r : AW'(count_r);

  always_comb begin
    if (state_r == S_MV_RD) begin
      ram_raddr = is_ins ? (idx_r - AW'(1)) : (idx_r + AW'(1));
    end else begin
      ram_raddr = idx_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    fidx_nxt      = fidx_r;
    pos_hit_nxt   = pos_hit_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = ram_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt     = in_req;
          idx_nxt     = '0;
          found_nxt   = 1'b0;
          pos_hit_nxt = 1'b0;
          state_nxt   = (count_r == '0) ? S_DECIDE : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (ent_eq) begin
          found_nxt = 1'b1;
          fidx_nxt  = idx_r;
        end
        if (!pos_hit_r && ent_after) begin
          pos_hit_nxt = 1'b1;
          pos_nxt     = idx_r;
        end
        if (ent_eq || last_scan) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        case (req_r.opcode)
          OP_INSERT: begin
            if (found_r) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{status: ST_DUPLICATE, entry_count: 7'(count_r)};
              state_nxt     = S_IDLE;
            end else if (count_r >= CW'(CAPACITY)) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{status: ST_FULL, entry_count: 7'(count_r)};
              state_nxt     = S_IDLE;
            end else begin
              pos_nxt   = ins_pos;
              idx_nxt   = AW'(count_r);
              state_nxt = (AW'(count_r) == ins_pos) ? S_WR_NEW : S_MV_RD;
            end
          end
          OP_DELETE: begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{status: ST_EMPTY, entry_count: 7'(count_r)};
              state_nxt     = S_IDLE;
            end else if (!found_r) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{status: ST_NOT_FOUND, entry_count: 7'(count_r)};
              state_nxt     = S_IDLE;
            end else if ((CW'(fidx_r) + CW'(1)) >= count_r) begin
              count_nxt     = count_r - CW'(1);
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{status: ST_DELETED, entry_count: 7'(count_r - CW'(1))};
              state_nxt     = S_IDLE;
            end else begin
              idx_nxt   = fidx_r;
              state_nxt = S_MV_RD;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (count_r == '0) begin
              out_rsp_nxt = '{status: ST_EMPTY, entry_count: 7'(count_r)};
            end else if (found_r) begin
              out_rsp_nxt = '{status: ST_FOUND, entry_count: 7'(count_r)};
            end else begin
              out_rsp_nxt = '{status: ST_NOT_FOUND, entry_count: 7'(count_r)};
            end
          end
        endcase
      end
      S_MV_RD: begin
        state_nxt = S_MV_WR;
      end
      S_MV_WR: begin
        ram_we = 1'b1;
        if (is_ins) begin
          idx_nxt   = idx_r - AW'(1);
          state_nxt = ((idx_r - AW'(1)) == pos_r) ? S_WR_NEW : S_MV_RD;
        end else begin
          idx_nxt = idx_r + AW'(1);
          if ((CW'(idx_r) + CW'(2)) >= count_r) begin
            count_nxt     = count_r - CW'(1);
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{status: ST_DELETED, entry_count: 7'(count_r - CW'(1))};
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_MV_RD;
          end
        end
      end
      S_WR_NEW: begin
        ram_we        = 1'b1;
        ram_waddr     = pos_r;
        ram_wdata     = req_r.value;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{status: ST_INSERTED, entry_count: 7'(count_r + CW'(1))};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      pos_hit_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      pos_hit_r   <= pos_hit_nxt;
      if (cfg_valid && cfg_ready) begin
        desc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    fidx_r    <= fidx_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/sse_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sse_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire sse_pkg::sse_rsp_t out_rsp
);

  import sse_pkg::*;

  logic rsp_known;

  assign rsp_known = (out_rsp.status != 3'd7);

  `SSE_ASSERT_IMPL(a_result_when_idle, clk, rst_n, out_valid, !busy)
  `SSE_ASSERT_NEXT(a_request_sets_busy, clk, rst_n, start && !busy, busy)
  `SSE_ASSERT_IMPL(a_result_after_work, clk, rst_n, out_valid, $past(busy))
  `SSE_ASSERT_NEXT(a_single_pulse, clk, rst_n, out_valid, !out_valid)
  `SSE_ASSERT_IMPL(a_status_legal, clk, rst_n, out_valid, rsp_known)

endmodule

bind sorted_set_engine_top sse_checker u_sse_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_rsp  (out_rsp)
);

`default_nettype wire
